[rtl/pbf_pkg.sv]
// Shared types, codes and constants for the packet byte FIFO with head drop.
// Used by the controller, datapath and top level.
`timescale 1ns / 1ps
package pbf_pkg;

    localparam int BUF_BYTES_DEF   = 4096;
    localparam int MAX_PACKETS_DEF = 64;
    localparam int CMD_W  = 2;
    localparam int LEN_W  = 16;
    localparam int HELD_W = 13;
    localparam int STAT_W = 3;
    localparam logic [HELD_W-1:0] MAX_BYTES_RST = 13'd4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_TOO_BIG = 3'd1,
        ST_ZERO    = 3'd2,
        ST_DROPPED = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DROP,
        S_READ,
        S_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic latch;      // capture the accepted request
        logic flush;
        logic discard;    // swallow one byte of a rejected packet
        logic reject;     // first byte of a too-large packet
        logic store;      // store the byte (continuation or first)
        logic first;      // first byte: reserve length in the queue
        logic drop;       // drop the head packet
        logic rd_issue;   // read the head byte from the store
        logic rd_done;    // advance past the byte read
        logic load_out;   // register the result
        t_status status;
        logic    valid;
    } t_ctl;

    // Datapath to controller.
    typedef struct packed {
        t_cmd cmd;
        logic incoming;    // r_left nonzero
        logic discarding;
        logic len_zero;
        logic too_big;
        logic need_drop;
        logic queue_empty;
    } t_sts;

endpackage

[rtl/pbf_if.sv]
// Valid/ready channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps
interface pbf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [15:0] packet_len;
    modport source (output valid, command, data_byte, packet_len, input ready);
    modport sink (input valid, command, data_byte, packet_len, output ready);
endinterface

interface pbf_res_if;
    logic        valid;
    logic        ready;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic [2:0]  status;
    logic [12:0] bytes_held;
    modport source (output valid, read_valid, read_byte, status, bytes_held, input ready);
    modport sink (input valid, read_valid, read_byte, status, bytes_held, output ready);
endinterface

interface pbf_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/pbf_ctrl.sv]
// Controller state machine for the packet byte FIFO.
// Depends on pbf_pkg; drives pbf_dp through t_ctl and watches t_sts.
`timescale 1ns / 1ps
module pbf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  logic           i_out_full,
    input  pbf_pkg::t_sts  i_sts,
    output pbf_pkg::t_ctl  o_ctl
);
    pbf_pkg::t_state r_state, n_state;
    logic r_dropped, n_dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pbf_pkg::S_IDLE;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_dropped   = r_dropped;
        o_ctl       = '0;
        o_ctl.status = pbf_pkg::ST_OK;
        o_req_ready = 1'b0;
        unique case (r_state)
            pbf_pkg::S_IDLE: begin
                o_req_ready = !i_out_full;
                if (i_req_valid && !i_out_full) begin
                    o_ctl.latch = 1'b1;
                    n_dropped   = 1'b0;
                    n_state     = pbf_pkg::S_DECIDE;
                end
            end
            pbf_pkg::S_DECIDE: begin
                o_ctl.load_out = 1'b1;
                n_state = pbf_pkg::S_IDLE;
                unique case (i_sts.cmd)
                    pbf_pkg::CMD_PUT: begin
                        if (i_sts.incoming) begin
                            if (i_sts.discarding) begin
                                o_ctl.discard = 1'b1;
                                o_ctl.status  = pbf_pkg::ST_TOO_BIG;
                            end else begin
                                o_ctl.store = 1'b1;
                            end
                        end else if (i_sts.len_zero) begin
                            o_ctl.status = pbf_pkg::ST_ZERO;
                        end else if (i_sts.too_big) begin
                            o_ctl.reject = 1'b1;
                            o_ctl.status = pbf_pkg::ST_TOO_BIG;
                        end else if (i_sts.need_drop) begin
                            o_ctl.load_out = 1'b0;
                            n_dropped  = 1'b1;
                            n_state    = pbf_pkg::S_DROP;
                        end else begin
                            o_ctl.store  = 1'b1;
                            o_ctl.first  = 1'b1;
                            o_ctl.status = r_dropped ? pbf_pkg::ST_DROPPED : pbf_pkg::ST_OK;
                        end
                    end
                    pbf_pkg::CMD_READ: begin
                        if (i_sts.queue_empty) begin
                            o_ctl.status = pbf_pkg::ST_EMPTY;
                        end else begin
                            o_ctl.load_out = 1'b0;
                            o_ctl.rd_issue = 1'b1;
                            n_state = pbf_pkg::S_READ;
                        end
                    end
                    pbf_pkg::CMD_FLUSH: o_ctl.flush = 1'b1;
                    default: ;
                endcase
            end
            pbf_pkg::S_DROP: begin
                // One head packet leaves per pass; the fit test is then rerun.
                o_ctl.drop = 1'b1;
                n_state = pbf_pkg::S_DECIDE;
            end
            pbf_pkg::S_READ: begin
                o_ctl.rd_done  = 1'b1;
                o_ctl.load_out = 1'b1;
                o_ctl.valid    = 1'b1;
                n_state = pbf_pkg::S_IDLE;
            end
            default: n_state = pbf_pkg::S_IDLE;
        endcase
    end
endmodule

[rtl/pbf_dp.sv]
// Datapath: byte store, length queue, pointers, counters and result register.
// Depends on pbf_pkg; commanded by pbf_ctrl.
`timescale 1ns / 1ps
module pbf_dp #(
    parameter int BUF_BYTES   = pbf_pkg::BUF_BYTES_DEF,
    parameter int MAX_PACKETS = pbf_pkg::MAX_PACKETS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_command,
    input  logic [7:0]                    i_data_byte,
    input  logic [pbf_pkg::LEN_W-1:0]     i_packet_len,
    input  logic                          i_cfg_we,
    input  logic [pbf_pkg::HELD_W-1:0]    i_cfg_data,
    input  pbf_pkg::t_ctl                 i_ctl,
    output pbf_pkg::t_sts                 o_sts,
    input  logic                          i_out_take,
    output logic                          o_out_full,
    output logic                          o_read_valid,
    output logic [7:0]                    o_read_byte,
    output logic [pbf_pkg::STAT_W-1:0]    o_status,
    output logic [pbf_pkg::HELD_W-1:0]    o_bytes_held
);
    localparam int AW = $clog2(BUF_BYTES);
    localparam int QW = $clog2(MAX_PACKETS);
    localparam int CW = $clog2(MAX_PACKETS + 1);
    localparam int HW = $clog2(BUF_BYTES + 1);
    localparam int LW = pbf_pkg::LEN_W;
    localparam int SW = (HW > LW ? HW : LW) + 1;
    localparam logic [SW-1:0] BUF_S = SW'(BUF_BYTES);

    logic [7:0]    r_mem [BUF_BYTES];
    logic [HW-1:0] r_lenq [MAX_PACKETS];

    logic [1:0]    r_cmd;
    logic [7:0]    r_data;
    logic [LW-1:0] r_plen;
    logic [pbf_pkg::HELD_W-1:0] r_max;
    logic [QW-1:0] r_qhead, r_qtail;
    logic [CW-1:0] r_qcount;
    logic [AW-1:0] r_rptr, r_wptr;
    logic [HW-1:0] r_held, r_roff;
    logic [LW-1:0] r_left;
    logic          r_disc;
    logic [HW-1:0] r_head_len;
    logic [7:0]    r_rbyte;
    logic          r_ofull;

    logic [SW-1:0] limit, held_sum, plen_s, max_s;
    logic [HW-1:0] unread, drop_held;
    logic [AW-1:0] new_rptr;
    logic [QW-1:0] tail_next, head_next;
    logic [LW-1:0] left_next;

    assign max_s  = SW'(r_max);
    assign limit  = (max_s > BUF_S) ? BUF_S : max_s;
    assign plen_s = SW'(r_plen);
    assign held_sum = SW'(r_held) + plen_s;
    assign unread   = (r_head_len >= r_roff) ? r_head_len - r_roff : '0;
    assign drop_held = (r_held >= r_head_len) ? r_held - r_head_len : '0;
    assign tail_next = (32'(r_qtail) + 1 >= MAX_PACKETS) ? '0 : r_qtail + 1'b1;
    assign head_next = (32'(r_qhead) + 1 >= MAX_PACKETS) ? '0 : r_qhead + 1'b1;
    assign left_next = (i_ctl.first ? r_plen : r_left) - 1'b1;

    // The unread count never exceeds the store size, so one subtraction wraps the sum.
    always_comb begin
        logic [HW:0] s;
        s = (HW+1)'(r_rptr) + (HW+1)'(unread);
        new_rptr = (s >= (HW+1)'(BUF_BYTES)) ? AW'(s - (HW+1)'(BUF_BYTES)) : AW'(s);
    end

    assign o_sts.cmd         = pbf_pkg::t_cmd'(r_cmd);
    assign o_sts.incoming    = (r_left != '0);
    assign o_sts.discarding  = r_disc;
    assign o_sts.len_zero    = (r_plen == '0);
    assign o_sts.too_big     = (plen_s > limit);
    assign o_sts.queue_empty = (r_qcount == '0);
    assign o_sts.need_drop   = (r_qcount != '0) &&
        ((held_sum > limit) || (32'(r_qcount) >= MAX_PACKETS));

    always_ff @(posedge i_clk) begin
        if (i_ctl.store) begin
            r_mem[r_wptr] <= r_data;
        end
        if (i_ctl.first) begin
            r_lenq[r_qtail] <= HW'(r_plen);
        end
        r_head_len <= r_lenq[r_qhead];
        if (i_ctl.rd_issue) begin
            r_rbyte <= r_mem[r_rptr];
        end
        if (i_ctl.latch) begin
            r_cmd  <= i_command;
            r_data <= i_data_byte;
            r_plen <= i_packet_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= pbf_pkg::MAX_BYTES_RST;
            r_qhead  <= '0;
            r_qtail  <= '0;
            r_qcount <= '0;
            r_rptr   <= '0;
            r_wptr   <= '0;
            r_held   <= '0;
            r_roff   <= '0;
            r_left   <= '0;
            r_disc   <= 1'b0;
            r_ofull  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            if (i_ctl.flush) begin
                r_qhead  <= '0;
                r_qtail  <= '0;
                r_qcount <= '0;
                r_rptr   <= '0;
                r_wptr   <= '0;
                r_held   <= '0;
                r_roff   <= '0;
                r_left   <= '0;
                r_disc   <= 1'b0;
            end
            if (i_ctl.discard) begin
                r_left <= r_left - 1'b1;
                if (r_left == LW'(1)) begin
                    r_disc <= 1'b0;
                end
            end
            if (i_ctl.reject) begin
                r_left <= r_plen - 1'b1;
                r_disc <= (r_plen != LW'(1));
            end
            if (i_ctl.drop) begin
                r_rptr   <= new_rptr;
                r_held   <= drop_held;
                r_roff   <= '0;
                r_qhead  <= head_next;
                r_qcount <= r_qcount - 1'b1;
            end
            if (i_ctl.store) begin
                r_wptr <= (32'(r_wptr) + 1 >= BUF_BYTES) ? '0 : r_wptr + 1'b1;
                r_left <= left_next;
                if (i_ctl.first) begin
                    r_held <= r_held + HW'(r_plen);
                end
                if (left_next == '0) begin
                    r_qtail  <= tail_next;
                    r_qcount <= r_qcount + 1'b1;
                end
            end
            if (i_ctl.rd_done) begin
                r_rptr <= (32'(r_rptr) + 1 >= BUF_BYTES) ? '0 : r_rptr + 1'b1;
                if (r_roff + 1'b1 >= r_head_len) begin
                    r_held   <= (r_held >= r_head_len) ? r_held - r_head_len : '0;
                    r_roff   <= '0;
                    r_qhead  <= head_next;
                    r_qcount <= r_qcount - 1'b1;
                end else begin
                    r_roff <= r_roff + 1'b1;
                end
            end
            if (i_ctl.load_out) begin
                r_ofull <= 1'b1;
            end else if (i_out_take) begin
                r_ofull <= 1'b0;
            end
        end
    end

    // The held count is registered together with the result, taken from the next state.
    logic [HW-1:0] held_after;
    always_comb begin
        held_after = r_held;
        if (i_ctl.flush) held_after = '0;
        if (i_ctl.first) held_after = r_held + HW'(r_plen);
        if (i_ctl.rd_done && (r_roff + 1'b1 >= r_head_len)) begin
            held_after = (r_held >= r_head_len) ? r_held - r_head_len : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            o_read_valid <= i_ctl.valid;
            o_read_byte  <= i_ctl.valid ? r_rbyte : 8'd0;
            o_status     <= i_ctl.status;
            o_bytes_held <= pbf_pkg::HELD_W'(held_after);
        end
    end

    assign o_out_full = r_ofull;
endmodule

[rtl/packet_byte_fifo_drop_oldest_unit.sv]
// Top level of the packet byte FIFO with head drop.
// Depends on pbf_pkg, the pbf interfaces, pbf_ctrl and pbf_dp.
//
// Requests enter on req (command, data_byte, packet_len) and every request
// gives exactly one result on res (read_valid, read_byte, status, bytes_held).
// A put or flush gives its result from the decide state; a read goes on
// to the read state, set by the registered read port of the byte store.
// The first byte of a packet that must make room passes the drop and
// decide states once more for each old packet dropped, one pass through
// the fit test and the length queue per packet. One request is in work
// at a time; the next is accepted in the cycle after its result is taken.
// The max_bytes register is written on cfg whenever it is valid; write it
// only while the block is idle. Reset empties the buffer and sets max_bytes
// to 4096; store contents are not cleared. When the receiver stalls the
// result is held and no new request is accepted.
`timescale 1ns / 1ps
module packet_byte_fifo_drop_oldest_unit #(
    parameter int BUF_BYTES   = pbf_pkg::BUF_BYTES_DEF,
    parameter int MAX_PACKETS = pbf_pkg::MAX_PACKETS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pbf_req_if.sink   req,
    pbf_res_if.source res,
    pbf_cfg_if.sink   cfg
);
    pbf_pkg::t_ctl ctl;
    pbf_pkg::t_sts sts;
    logic out_full;

    assign cfg.ready = 1'b1;
    assign res.valid = out_full;

    pbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req.valid),
        .o_req_ready (req.ready),
        .i_out_full  (out_full),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    pbf_dp #(
        .BUF_BYTES   (BUF_BYTES),
        .MAX_PACKETS (MAX_PACKETS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_command    (req.command),
        .i_data_byte  (req.data_byte),
        .i_packet_len (req.packet_len),
        .i_cfg_we     (cfg.valid),
        .i_cfg_data   (cfg.data),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_out_take   (res.ready),
        .o_out_full   (out_full),
        .o_read_valid (res.read_valid),
        .o_read_byte  (res.read_byte),
        .o_status     (res.status),
        .o_bytes_held (res.bytes_held)
    );
endmodule

[tb/packet_byte_fifo_drop_oldest_unit_tb.sv]
// Testbench for the packet byte FIFO with head drop: directed and random requests,
// checked result by result against a behavioral predictor. Depends on pbf_pkg and pbf_if.
`timescale 1ns / 1ps
module packet_byte_fifo_drop_oldest_unit_tb;

    localparam int NBUF = pbf_pkg::BUF_BYTES_DEF;
    localparam int NPKT = pbf_pkg::MAX_PACKETS_DEF;

    typedef struct packed {
        pbf_pkg::t_cmd command;
        logic [7:0]    data_byte;
        logic [15:0]   packet_len;
    } t_request;

    typedef struct packed {
        logic             read_valid;
        logic [7:0]       read_byte;
        pbf_pkg::t_status status;
        logic [12:0]      bytes_held;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pbf_req_if req ();
    pbf_res_if res ();
    pbf_cfg_if cfg ();

    packet_byte_fifo_drop_oldest_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req.sink), .res(res.source), .cfg(cfg.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    logic [7:0]  buf_bytes [NBUF];
    logic [12:0] pkt_lens [NPKT];
    int unsigned p_head, p_tail, p_count, rd_ptr, wr_ptr, held, rd_off, arriving;
    bit          discarding;
    int unsigned byte_limit;

    t_request request_queue [$];
    t_outcome expected_outcomes [$];
    int errors = 0;
    int sender_idle_pct = 25;
    int receiver_idle_pct = 54;
    bit cfg_busy = 1'b0;
    bit req_fire = 1'b0;
    logic [12:0] cfg_value;

    function automatic int unsigned wrap_add(int unsigned p, int unsigned n);
        return (p + n) % NBUF;
    endfunction

    function automatic void drop_oldest();
        int unsigned len;
        len = pkt_lens[p_head];
        rd_ptr = wrap_add(rd_ptr, (len >= rd_off) ? len - rd_off : 0);
        held = (held >= len) ? held - len : 0;
        rd_off = 0;
        p_head = (p_head + 1) % NPKT;
        p_count--;
    endfunction

    function automatic void keep_byte(logic [7:0] b);
        buf_bytes[wr_ptr] = b;
        wr_ptr = wrap_add(wr_ptr, 1);
        arriving--;
        if (arriving == 0) begin
            p_tail = (p_tail + 1) % NPKT;
            p_count++;
        end
    endfunction

    function automatic t_outcome predict_outcome(t_request r);
        t_outcome o;
        int unsigned len;
        int unsigned lim;
        o = '0;
        o.status = pbf_pkg::ST_OK;
        lim = (byte_limit > NBUF) ? NBUF : byte_limit;
        case (r.command)
            pbf_pkg::CMD_PUT: begin
                if (arriving != 0) begin
                    if (discarding) begin
                        arriving--;
                        if (arriving == 0) discarding = 1'b0;
                        o.status = pbf_pkg::ST_TOO_BIG;
                    end else begin
                        keep_byte(r.data_byte);
                    end
                end else if (r.packet_len == 0) begin
                    o.status = pbf_pkg::ST_ZERO;
                end else if (r.packet_len > lim) begin
                    o.status = pbf_pkg::ST_TOO_BIG;
                    arriving = r.packet_len - 1;
                    discarding = (arriving != 0);
                end else begin
                    while (p_count > 0 && (held + r.packet_len > lim || p_count >= NPKT)) begin
                        drop_oldest();
                        o.status = pbf_pkg::ST_DROPPED;
                    end
                    pkt_lens[p_tail] = r.packet_len;
                    held += r.packet_len;
                    arriving = r.packet_len;
                    keep_byte(r.data_byte);
                end
            end
            pbf_pkg::CMD_READ: begin
                if (p_count == 0) begin
                    o.status = pbf_pkg::ST_EMPTY;
                end else begin
                    len = pkt_lens[p_head];
                    o.read_byte = buf_bytes[rd_ptr];
                    o.read_valid = 1'b1;
                    rd_ptr = wrap_add(rd_ptr, 1);
                    rd_off++;
                    if (rd_off >= len) begin
                        held = (held >= len) ? held - len : 0;
                        rd_off = 0;
                        p_head = (p_head + 1) % NPKT;
                        p_count--;
                    end
                end
            end
            pbf_pkg::CMD_FLUSH: begin
                p_head = 0; p_tail = 0; p_count = 0; rd_ptr = 0; wr_ptr = 0;
                held = 0; rd_off = 0; arriving = 0; discarding = 1'b0;
            end
            default: ;
        endcase
        o.bytes_held = held[12:0];
        return o;
    endfunction

    // Driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 1'b0;
        end else if (!req.valid || req_fire) begin
            if (request_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                req.valid <= 1'b1;
                {req.command, req.data_byte, req.packet_len} <= request_queue.pop_front();
            end else begin
                req.valid <= 1'b0;
            end
        end
        res.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Predict on acceptance, then check results.
    always @(posedge i_clk) begin
        t_request r;
        t_outcome got, want;
        req_fire <= i_rst_n && req.valid && req.ready;
        if (i_rst_n && req.valid && req.ready) begin
            r.command = pbf_pkg::t_cmd'(req.command);
            r.data_byte = req.data_byte;
            r.packet_len = req.packet_len;
            expected_outcomes.push_back(predict_outcome(r));
        end
        if (i_rst_n && res.valid && res.ready) begin
            got.read_valid = res.read_valid;
            got.read_byte = res.read_byte;
            got.status = pbf_pkg::t_status'(res.status);
            got.bytes_held = res.bytes_held;
            if (expected_outcomes.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result %h", got);
            end else begin
                want = expected_outcomes.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"Mismatch: expected valid=%0d byte=%0d st=%0d held=%0d,",
                                  " got valid=%0d byte=%0d st=%0d held=%0d"},
                            want.read_valid, want.read_byte, want.status, want.bytes_held,
                            got.read_valid, got.read_byte, got.status, got.bytes_held);
                end
            end
        end
    end

    // Configuration write channel.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cfg.valid <= 1'b0;
        end else if (cfg.valid && cfg.ready) begin
            cfg.valid <= 1'b0;
        end else if (cfg_busy && !cfg.valid) begin
            cfg.valid <= 1'b1;
            cfg.data <= cfg_value;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cfg.valid && cfg.ready) begin
            byte_limit = cfg.data;
            cfg_busy <= 1'b0;
        end
    end

    task automatic push_request(pbf_pkg::t_cmd c, logic [7:0] d, logic [15:0] l);
        t_request r;
        r.command = c;
        r.data_byte = d;
        r.packet_len = l;
        request_queue.push_back(r);
    endtask

    task automatic push_packet(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            push_request(pbf_pkg::CMD_PUT, 8'($urandom), (i == 0) ? 16'(len) : 16'($urandom));
    endtask

    task automatic drain_all();
        while (request_queue.size() > 0 || expected_outcomes.size() > 0 || req.valid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [12:0] v);
        drain_all();
        cfg_value = v;
        cfg_busy = 1'b1;
        while (cfg_busy) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic random_phase(int items, int unsigned max_len);
        int sent;
        int unsigned pick, len;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(max_len) :
                      $urandom_range(1, (max_len < 12) ? max_len : 12);
                if (len == 0) len = 1;
                if ($urandom_range(19) == 0) len = 16'($urandom);
                if (len > 200) begin
                    push_request(pbf_pkg::CMD_PUT, 8'($urandom), 16'(len));
                    sent++;
                    continue;
                end
                push_packet(len);
                sent += len;
            end else if (pick < 90) begin
                push_request(pbf_pkg::CMD_READ, 8'($urandom), 16'($urandom));
                sent++;
            end else if (pick < 93) begin
                push_request(pbf_pkg::CMD_FLUSH, 8'($urandom), 16'($urandom));
                sent++;
            end else if (pick < 95) begin
                push_request(pbf_pkg::CMD_NOP, 8'($urandom), 16'($urandom));
                sent++;
            end else begin
                push_request(pbf_pkg::CMD_PUT, 8'($urandom), 16'($urandom_range(3)));
                sent++;
            end
        end
        push_request(pbf_pkg::CMD_FLUSH, 8'h00, 16'h0000);
    endtask

    initial begin
        req.valid = 1'b0;
        req.command = pbf_pkg::CMD_NOP;
        req.data_byte = '0;
        req.packet_len = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        byte_limit = pbf_pkg::MAX_BYTES_RST;
        p_head = 0; p_tail = 0; p_count = 0; rd_ptr = 0; wr_ptr = 0;
        held = 0; rd_off = 0; arriving = 0; discarding = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests.
        push_request(pbf_pkg::CMD_READ, 8'h00, 16'h0000);
        push_request(pbf_pkg::CMD_PUT, 8'hff, 16'h0000);
        push_packet(3);
        push_request(pbf_pkg::CMD_READ, 8'hff, 16'hffff);
        push_request(pbf_pkg::CMD_PUT, 8'h00, 16'hffff);
        push_request(pbf_pkg::CMD_PUT, 8'h55, 16'h0001);
        push_request(pbf_pkg::CMD_NOP, 8'haa, 16'h5555);
        push_request(pbf_pkg::CMD_READ, 8'h00, 16'h0000);
        push_request(pbf_pkg::CMD_READ, 8'h00, 16'h0000);
        push_request(pbf_pkg::CMD_READ, 8'h00, 16'h0000);
        push_request(pbf_pkg::CMD_READ, 8'h00, 16'h0000);
        push_request(pbf_pkg::CMD_FLUSH, 8'h00, 16'haaaa);
        drain_all();

        write_limit(13'd8);
        push_packet(5);
        push_request(pbf_pkg::CMD_READ, 8'h00, 16'h0000);
        push_packet(4);
        push_request(pbf_pkg::CMD_PUT, 8'h00, 16'd9);
        push_packet(8);
        push_request(pbf_pkg::CMD_FLUSH, 8'h00, 16'h0000);
        drain_all();

        // Queue-full drop with one-byte packets.
        write_limit(13'd4096);
        for (int i = 0; i < 66; i++) push_packet(1);
        for (int i = 0; i < 3; i++) push_request(pbf_pkg::CMD_READ, 8'h00, 16'h0000);
        push_packet(40);
        push_request(pbf_pkg::CMD_READ, 8'h00, 16'h0000);
        push_request(pbf_pkg::CMD_FLUSH, 8'h00, 16'h0000);
        drain_all();

        write_limit(13'd0);
        push_request(pbf_pkg::CMD_PUT, 8'h12, 16'd1);
        drain_all();
        write_limit(13'h1fff);
        push_request(pbf_pkg::CMD_PUT, 8'h12, 16'd4097);
        push_request(pbf_pkg::CMD_FLUSH, 8'h00, 16'h0000);

        sender_idle_pct = 25; receiver_idle_pct = 54;
        random_phase(230, 40);
        write_limit(13'd1);
        sender_idle_pct = 54; receiver_idle_pct = 25;
        random_phase(120, 3);
        write_limit(13'd30);
        random_phase(110, 40);
        write_limit(13'd4096);
        sender_idle_pct = 0; receiver_idle_pct = 0;
        random_phase(240, 60);
        drain_all();

        if (errors == 0 && expected_outcomes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
